[rtl/core/lrs_pkg.sv]
`default_nettype none

package lrs_pkg;

    localparam int DEPTH_DEF    = 64;
    localparam int TAG_BITS_DEF = 48;
    localparam int LINE_BITS    = 48;
    localparam int AGE_BITS     = 16;
    localparam int CFG_BITS     = 7;

    localparam logic [CFG_BITS-1:0] CFG_RESET = 7'd64;
    localparam logic [AGE_BITS-1:0] AGE_MAX   = '1;

    typedef enum logic {
        CMD_ACCESS = 1'b0,
        CMD_QUERY  = 1'b1
    } cmd_t;

    typedef struct packed {
        cmd_t                 cmd;
        logic [LINE_BITS-1:0] line_id;
    } req_t;

    typedef struct packed {
        logic                found;
        logic [AGE_BITS-1:0] age;
    } rsp_t;

    typedef struct packed {
        logic clear;
        logic load;
    } cell_ctl_t;

    function automatic logic [AGE_BITS-1:0] age_up(input logic [AGE_BITS-1:0] a);
        logic [AGE_BITS-1:0] r;
        if (a == AGE_MAX)
            r = AGE_MAX;
        else
            r = a + AGE_BITS'(1);
        return r;
    endfunction

endpackage

`default_nettype wire

[rtl/core/lrs_cell.sv]
`default_nettype none

module lrs_cell
    import lrs_pkg::*;
#(
    parameter int TAG_BITS = TAG_BITS_DEF
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire cell_ctl_t           ctl,
    input  wire logic [TAG_BITS-1:0] up_tag,
    input  wire logic                up_valid,
    input  wire logic [AGE_BITS-1:0] up_age,
    input  wire logic [TAG_BITS-1:0] cmp_tag,
    output logic [TAG_BITS-1:0]      tag,
    output logic                     valid,
    output logic [AGE_BITS-1:0]      age,
    output logic [AGE_BITS-1:0]      aged,
    output logic                     match
);

    logic [TAG_BITS-1:0] tag_reg;
    logic                valid_reg;
    logic [AGE_BITS-1:0] age_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (ctl.clear)
        begin
            valid_reg <= 1'b0;
        end
        else if (ctl.load)
        begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            tag_reg <= up_tag;
            age_reg <= up_age;
        end
    end

    assign tag   = tag_reg;
    assign valid = valid_reg;
    assign age   = age_reg;
    assign aged  = age_up(age_reg);
    assign match = valid_reg && (tag_reg == cmp_tag);

endmodule

`default_nettype wire

[rtl/core/lru_stack_reuse_distance_core.sv]
// Requests are registered on acceptance; a response is registered when the output slot frees.
// Throughput: one request per cycle while responses are taken; a held response stalls intake.
// Each cycle all cells compare in parallel, and on an access the stack shifts one cell at once.
// Reset clears every cell valid bit at once (no sweep) and sets the active count to 64.
// A config write of a new active count clears the stack in that same cycle.
`default_nettype none

module lru_stack_reuse_distance_core
    import lrs_pkg::*;
#(
    parameter int DEPTH    = DEPTH_DEF,
    parameter int TAG_BITS = TAG_BITS_DEF
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                req_valid,
    output logic                     req_ready,
    input  wire req_t                req_data,
    output logic                     rsp_valid,
    input  wire logic                rsp_ready,
    output rsp_t                     rsp_data,
    input  wire logic                cfg_valid,
    output logic                     cfg_ready,
    input  wire logic [CFG_BITS-1:0] cfg_data
);

    localparam int CMP_W = (CFG_BITS > $clog2(DEPTH) + 1) ? CFG_BITS : $clog2(DEPTH) + 1;

    logic                req_valid_reg;
    cmd_t                req_cmd_reg;
    logic [TAG_BITS-1:0] req_tag_reg;
    logic                rsp_valid_reg;
    rsp_t                rsp_reg;
    logic [CFG_BITS-1:0] active_reg;

    logic                done;
    logic                access_go;
    logic                clear;
    logic [AGE_BITS-1:0] hit_age;

    logic [DEPTH-1:0]    cell_active;
    logic [DEPTH-1:0]    cell_match;
    logic [DEPTH-1:0]    cell_valid;
    logic [DEPTH-1:0]    hit_vec;
    logic [DEPTH-1:0]    pre_hit;
    logic [TAG_BITS-1:0] cell_tag  [DEPTH];
    logic [AGE_BITS-1:0] cell_age  [DEPTH];
    logic [AGE_BITS-1:0] cell_aged [DEPTH];
    cell_ctl_t           cell_ctl  [DEPTH];

    assign done      = req_valid_reg && (!rsp_valid_reg || rsp_ready);
    assign access_go = done && (req_cmd_reg == CMD_ACCESS);
    assign req_ready = !req_valid_reg || done;
    assign cfg_ready = 1'b1;
    assign clear     = cfg_valid && cfg_ready && (cfg_data != active_reg);

    // request capture
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid_reg <= 1'b0;
        end
        else if (req_ready)
        begin
            req_valid_reg <= req_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_valid && req_ready)
        begin
            req_cmd_reg <= req_data.cmd;
            req_tag_reg <= TAG_BITS'(req_data.line_id);
        end
    end

    // active count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= CFG_RESET;
        end
        else if (clear)
        begin
            active_reg <= cfg_data;
        end
    end

    // cell row
    genvar i;
    generate
        for (i = 0; i < DEPTH; i++)
        begin : g_cell
            logic [TAG_BITS-1:0] up_tag;
            logic                up_valid;
            logic [AGE_BITS-1:0] up_age;

            if (i == 0)
            begin : g_top
                assign up_tag     = req_tag_reg;
                assign up_valid   = 1'b1;
                assign up_age     = '0;
                assign pre_hit[i] = 1'b0;
                assign cell_active[i] = 1'b1;
            end
            else
            begin : g_body
                assign up_tag     = cell_tag[i-1];
                assign up_valid   = cell_valid[i-1];
                assign up_age     = cell_aged[i-1];
                assign pre_hit[i] = |hit_vec[i-1:0];
                assign cell_active[i] = CMP_W'(i) < CMP_W'(active_reg);
            end

            assign hit_vec[i]       = cell_match[i] && cell_active[i];
            assign cell_ctl[i].clear = clear;
            assign cell_ctl[i].load  = access_go && cell_active[i] && !pre_hit[i];

            lrs_cell #(
                .TAG_BITS (TAG_BITS)
            ) u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .ctl      (cell_ctl[i]),
                .up_tag   (up_tag),
                .up_valid (up_valid),
                .up_age   (up_age),
                .cmp_tag  (req_tag_reg),
                .tag      (cell_tag[i]),
                .valid    (cell_valid[i]),
                .age      (cell_age[i]),
                .aged     (cell_aged[i]),
                .match    (cell_match[i])
            );
        end
    endgenerate

    // at most one active cell matches, so an OR picks its age
    always_comb
    begin
        hit_age = '0;
        for (int k = 0; k < DEPTH; k++)
        begin
            if (hit_vec[k])
                hit_age = hit_age | cell_age[k];
        end
    end

    // response register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (done)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (done)
        begin
            rsp_reg.found <= |hit_vec;
            rsp_reg.age   <= hit_age;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_reg;

`ifndef SYNTH
    a_unique_hit: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid_reg |-> $onehot0(hit_vec))
        else $error("more than one active cell matches");

    a_rsp_loaded: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> rsp_valid_reg)
        else $error("finished request left no response");

    a_top_after_access: assert property (@(posedge clk) disable iff (!rst_n)
        (access_go && !clear) |=> (cell_valid[0] && (cell_age[0] == '0)))
        else $error("accessed line not on top with age zero");

    a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
        clear |=> (cell_valid == '0))
        else $error("stack not empty after active count change");
`endif

endmodule

`default_nettype wire

[dv/tb.sv]
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import lrs_pkg::*;

    localparam int STACK_DEPTH = 64;
    localparam int QUIET_LIMIT = 2000;
    localparam int SETTLE_CYCLES = 4;
    localparam int ITEMS_PER_SETTING = 140;
    localparam logic [CFG_BITS-1:0] ACTIVE_PLAN [12] =
        '{7'd64, 7'd3, 7'd127, 7'd16, 7'd1, 7'd40, 7'd0, 7'd8, 7'd65, 7'd2, 7'd100, 7'd12};

    logic                clk;
    logic                rst_n;
    logic                req_valid;
    logic                req_ready;
    req_t                req_data;
    logic                rsp_valid;
    logic                rsp_ready;
    rsp_t                rsp_data;
    logic                cfg_valid;
    logic                cfg_ready;
    logic [CFG_BITS-1:0] cfg_data;

    // predicted stack, position 0 is most recent
    logic [LINE_BITS-1:0] stk_tag   [STACK_DEPTH];
    logic                 stk_valid [STACK_DEPTH];
    logic [AGE_BITS-1:0]  stk_age   [STACK_DEPTH];
    logic [CFG_BITS-1:0]  held_active;

    rsp_t                 pending_rsp [$];
    rsp_t                 want_rsp;
    logic [LINE_BITS-1:0] line_pool [STACK_DEPTH + 1 + STACK_DEPTH / 8];
    int                   pool_size;
    int                   send_idle_pct;
    int                   recv_idle_pct;
    int                   mismatch_count;
    int                   quiet_cycles;

    lru_stack_reuse_distance_core uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req_data  (req_data),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp_data  (rsp_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    function automatic void clear_stack();
        int i;
        for (i = 0; i < STACK_DEPTH; i++)
        begin
            stk_tag[i]   = '1;
            stk_valid[i] = 1'b0;
            stk_age[i]   = '1;
        end
    endfunction

    function automatic int active_depth();
        int n;
        n = int'(held_active);
        if (n == 0)
            n = 1;
        else if (n > STACK_DEPTH)
            n = STACK_DEPTH;
        return n;
    endfunction

    function automatic rsp_t lru_access(cmd_t c, logic [LINE_BITS-1:0] id);
        int   n;
        int   hit;
        int   aged;
        int   i;
        rsp_t r;
        n   = active_depth();
        hit = -1;
        for (i = 0; i < n; i++)
        begin
            if (hit < 0 && stk_valid[i] && stk_tag[i] == id)
                hit = i;
        end
        r.found = (hit >= 0);
        r.age   = (hit >= 0) ? stk_age[hit] : '0;
        if (c == CMD_ACCESS)
        begin
            aged = (hit >= 0) ? hit : n;
            // ages saturate
            for (i = 0; i < aged; i++)
                stk_age[i] = (stk_age[i] == '1) ? stk_age[i] : stk_age[i] + 1'b1;
            for (i = (hit >= 0) ? hit : n - 1; i > 0; i--)
            begin
                stk_tag[i]   = stk_tag[i-1];
                stk_valid[i] = stk_valid[i-1];
                stk_age[i]   = stk_age[i-1];
            end
            stk_tag[0]   = id;
            stk_valid[0] = 1'b1;
            stk_age[0]   = '0;
        end
        return r;
    endfunction

    function automatic logic [LINE_BITS-1:0] rand_line();
        logic [63:0] r;
        r = {$urandom(), $urandom()};
        return r[LINE_BITS-1:0];
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("mismatch: %s got %0h expected %0h at %0t", what, got, want, $realtime);
        mismatch_count++;
    endtask

    task automatic send_req(cmd_t c, logic [LINE_BITS-1:0] id);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_valid <= 1'b0;
            @(negedge clk);
        end
        req_valid <= 1'b1;
        req_data  <= '{cmd: c, line_id: id};
        do
            @(posedge clk);
        while (!req_ready);
        pending_rsp.push_back(lru_access(c, id));
    endtask

    task automatic drain_pipeline();
        @(negedge clk);
        req_valid <= 1'b0;
        while (pending_rsp.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // new count clears the stack, same count leaves it
    task automatic write_active(logic [CFG_BITS-1:0] v);
        drain_pipeline();
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do
            @(posedge clk);
        while (!cfg_ready);
        if (v != held_active)
        begin
            held_active = v;
            clear_stack();
        end
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    always @(negedge clk)
        rsp_ready <= ($urandom_range(99) >= recv_idle_pct);

    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && rsp_ready)
        begin
            if (pending_rsp.size() == 0)
                report_mismatch("unexpected response", rsp_data, 0);
            else
            begin
                want_rsp = pending_rsp.pop_front();
                if (rsp_data.found !== want_rsp.found)
                    report_mismatch("found", rsp_data.found, want_rsp.found);
                if (rsp_data.age !== want_rsp.age)
                    report_mismatch("age", rsp_data.age, want_rsp.age);
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (req_valid && req_ready) || (rsp_valid && rsp_ready)
            || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // empty model entries hold an all-ones tag, but empty cells must never match
    task automatic test_empty_entries();
        send_req(CMD_QUERY,  '1);
        send_req(CMD_ACCESS, '1);
        send_req(CMD_QUERY,  '1);
        send_req(CMD_ACCESS, '0);
        send_req(CMD_QUERY,  '1);
        send_req(CMD_ACCESS, '1);
        send_req(CMD_QUERY,  '0);
    endtask

    task automatic test_active_count();
        logic [LINE_BITS-1:0] la;
        logic [LINE_BITS-1:0] lb;
        la = 48'h0000_0000_0001;
        lb = 48'h8000_0000_0000;
        // zero behaves as a single entry
        write_active(7'd0);
        send_req(CMD_ACCESS, la);
        send_req(CMD_ACCESS, lb);
        send_req(CMD_QUERY,  la);
        send_req(CMD_QUERY,  lb);
        write_active(7'd0);
        send_req(CMD_QUERY,  lb);
        write_active(7'd127);
        send_req(CMD_QUERY,  lb);
        send_req(CMD_ACCESS, lb);
        write_active(7'd64);
    endtask

    task automatic test_line_extremes();
        logic [LINE_BITS-1:0] p5;
        logic [LINE_BITS-1:0] pa;
        p5 = 48'h5555_5555_5555;
        pa = 48'hAAAA_AAAA_AAAA;
        send_req(CMD_ACCESS, p5);
        send_req(CMD_ACCESS, pa);
        send_req(CMD_ACCESS, p5 ^ 48'h8000_0000_0000);
        send_req(CMD_QUERY,  pa ^ 48'h0000_0000_0001);
        send_req(CMD_QUERY,  p5);
        send_req(CMD_ACCESS, pa);
        send_req(CMD_QUERY,  p5);
    endtask

    task automatic test_random_traffic(int s_idle, int r_idle, int first_setting);
        int k;
        int i;
        int sel;
        int n;
        logic [LINE_BITS-1:0] id;
        cmd_t c;
        send_idle_pct = s_idle;
        recv_idle_pct = r_idle;
        for (k = 0; k < 4; k++)
        begin
            write_active(ACTIVE_PLAN[first_setting + k]);
            n = active_depth();
            // a pool slightly larger than the stack mixes hits, misses and evictions
            pool_size = n + 1 + n / 8;
            for (i = 0; i < pool_size; i++)
                line_pool[i] = rand_line();
            repeat (ITEMS_PER_SETTING)
            begin
                sel = $urandom_range(99);
                if (sel < 85)
                    id = line_pool[$urandom_range(pool_size - 1)];
                else if (sel < 92)
                    id = line_pool[$urandom_range(pool_size - 1)]
                         ^ (48'd1 << $urandom_range(LINE_BITS - 1));
                else
                    id = rand_line();
                c = ($urandom_range(3) == 0) ? CMD_QUERY : CMD_ACCESS;
                send_req(c, id);
            end
        end
    endtask

    initial
    begin
        rst_n          = 1'b0;
        req_valid      = 1'b0;
        req_data       = '0;
        rsp_ready      = 1'b0;
        cfg_valid      = 1'b0;
        cfg_data       = '0;
        mismatch_count = 0;
        quiet_cycles   = 0;
        send_idle_pct  = 33;
        recv_idle_pct  = 56;
        held_active    = CFG_RESET;
        clear_stack();
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_empty_entries();
        test_active_count();
        test_line_extremes();
        test_random_traffic(33, 56, 0);
        test_random_traffic(56, 33, 4);
        test_random_traffic(0, 0, 8);
        drain_pipeline();

        if (mismatch_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
